// ===== sv/nfa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types, constants and feature index helpers of the feature accumulator
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int HALF_WIDTH_DEFAULT = 256;
    localparam int FEATURE_COUNT      = 41024;
    localparam int KING_STRIDE        = 10 * 64 + 1;
    localparam logic [5:0] SQUARE_MASK = 6'h3f;

    typedef enum logic [2:0] {
        OP_LOAD_WEIGHT = 3'd0,
        OP_LOAD_BIAS   = 3'd1,
        OP_REFRESH     = 3'd2,
        OP_ADD         = 3'd3,
        OP_REMOVE      = 3'd4,
        OP_READ        = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEATURE,
        ST_BASE,
        ST_WLOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    localparam logic [9:0] PIECE_OFFSET [0:1][0:15] = '{
        '{10'd0, 10'd65, 10'd193, 10'd321, 10'd449, 10'd577, 10'd0, 10'd0,
          10'd0, 10'd1, 10'd129, 10'd257, 10'd385, 10'd513, 10'd0, 10'd0},
        '{10'd0, 10'd1, 10'd129, 10'd257, 10'd385, 10'd513, 10'd0, 10'd0,
          10'd0, 10'd65, 10'd193, 10'd321, 10'd449, 10'd577, 10'd0, 10'd0}
    };

    function automatic logic [5:0] flip_square(input logic persp, input logic [5:0] sq);
        return (sq ^ 6'd7) ^ (persp ? 6'd0 : SQUARE_MASK);
    endfunction

    function automatic logic [15:0] compute_feature(
        input logic       persp,
        input logic [5:0] king_sq,
        input logic [5:0] sq,
        input logic [2:0] ptype,
        input logic       pcolor
    );
        logic [3:0] code;
        logic [9:0] off;
        logic [5:0] fsq;
        logic [5:0] fksq;
        off  = 10'd0;
        code = 4'd0;
        fsq  = flip_square(persp, sq);
        fksq = flip_square(persp, king_sq);
        if (ptype inside {[3'd1:3'd5]})
        begin
            code = (pcolor ? 4'd6 : 4'd14) - {1'b0, ptype};
            off  = PIECE_OFFSET[persp][code];
        end
        return {10'd0, fsq} + {6'd0, off} + 16'(KING_STRIDE) * {10'd0, fksq};
    endfunction

endpackage

// ===== sv/nfa_ram.sv =====
// ----------------------------------------------------------------------------
// nfa_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module nfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/nnue_feature_accumulator.sv =====
// ----------------------------------------------------------------------------
// nnue_feature_accumulator
// two perspective accumulators updated from a loaded weight row store
// ----------------------------------------------------------------------------
// one request channel (in_valid/in_ready) carries an operation and its fields,
// one result channel (out_valid/out_ready) returns read_value and used_feature
// for every request. requests are taken one at a time: in_ready is high only
// while the sequencer is idle.
// every request passes the feature and base states, then:
//   add, remove, refresh : a sweep with one read-modify-write of an
//                          accumulator element per cycle through the single
//                          accumulator ram port pair and one shared adder
//   weight load          : row base multiply, then the write
//   read                 : accumulator read issued in the base state, then a wait
//   bias load, unused op : straight to finish; a bias load writes in the base state
// the sequencer takes the next request in the idle cycle after the previous
// one has reached the result register.
// reset clears both accumulator halves at once through one valid bit per half;
// a half that is not valid reads as zero. weight and bias stores are not
// cleared. a stalled receiver holds the result register; the block still
// takes and works a new request and waits before its own result until the
// held result is taken.
// ----------------------------------------------------------------------------
module nnue_feature_accumulator
    import nfa_pkg::*;
#(
    parameter int HALF_WIDTH = HALF_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic               perspective,
    input  logic [5:0]         king_square,
    input  logic [5:0]         square,
    input  logic [2:0]         piece_type,
    input  logic               piece_color,
    input  logic [15:0]        feature_index,
    input  logic [7:0]         element_index,
    input  logic signed [15:0] load_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_value,
    output logic [15:0]        used_feature
);

    localparam int IW = $clog2(HALF_WIDTH);
    localparam int AW = $clog2(2 * HALF_WIDTH);
    localparam int WDEPTH = FEATURE_COUNT * HALF_WIDTH;
    localparam int WA = $clog2(WDEPTH);
    localparam logic [WA-1:0] ROW_STRIDE = WA'(HALF_WIDTH);
    localparam logic [AW-1:0] HALF_BASE = AW'(HALF_WIDTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(HALF_WIDTH - 1);

    state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic        persp_reg;
    logic [5:0]  ksq_reg;
    logic [5:0]  sq_reg;
    logic [2:0]  ptype_reg;
    logic        pcolor_reg;
    logic [15:0] fidx_reg;
    logic [7:0]  eidx_reg;
    logic [15:0] lval_reg;

    logic [15:0]   feat_reg, feat_next;
    logic [WA-1:0] base_reg, base_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          wb_valid_reg, wb_valid_next;
    logic [IW-1:0] wb_idx_reg, wb_idx_next;
    logic [1:0]    row_valid_reg, row_valid_next;
    logic [31:0]   rd_res_reg, rd_res_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   read_value_reg, read_value_next;
    logic [15:0]   used_feature_reg, used_feature_next;

    logic          accept;
    logic          eidx_ok;
    logic          fidx_ok;
    logic          out_free;
    logic [15:0]   row_sel;

    logic          w_we, w_re;
    logic [WA-1:0] w_waddr, w_raddr;
    logic [15:0]   w_rdata;
    logic          b_we, b_re;
    logic [IW-1:0] b_waddr;
    logic [15:0]   b_rdata;
    logic          a_we, a_re;
    logic [AW-1:0] a_waddr, a_raddr;
    logic [31:0]   a_wdata, a_rdata;
    logic [31:0]   a_old;
    logic [31:0]   w_ext;
    logic [31:0]   b_ext;

    assign accept   = in_valid && in_ready;
    assign eidx_ok  = 32'(eidx_reg) < HALF_WIDTH;
    assign fidx_ok  = 32'(fidx_reg) < FEATURE_COUNT;
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign used_feature = used_feature_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FEATURE;
                end
            end
            ST_FEATURE:
            begin
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                case (op_reg)
                    OP_LOAD_WEIGHT: state_next = ST_WLOAD;
                    OP_REFRESH, OP_ADD, OP_REMOVE: state_next = ST_SWEEP;
                    OP_READ: state_next = ST_READ_WAIT;
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_WLOAD:
            begin
                state_next = ST_FINISH;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign row_sel = (op_reg == OP_LOAD_WEIGHT) ? fidx_reg : feat_reg;
    assign w_ext   = {{16{w_rdata[15]}}, w_rdata};
    assign b_ext   = {{16{b_rdata[15]}}, b_rdata};
    assign a_old   = row_valid_reg[persp_reg] ? a_rdata : 32'd0;

    // outputs and datapath controls
    always_comb
    begin
        feat_next         = feat_reg;
        base_next         = base_reg;
        cnt_next          = cnt_reg;
        wb_valid_next     = 1'b0;
        wb_idx_next       = wb_idx_reg;
        row_valid_next    = row_valid_reg;
        rd_res_next       = rd_res_reg;
        out_valid_next    = out_valid_reg;
        read_value_next   = read_value_reg;
        used_feature_next = used_feature_reg;

        w_we    = 1'b0;
        w_waddr = base_reg + WA'(eidx_reg);
        w_re    = 1'b0;
        w_raddr = base_reg + WA'(cnt_reg);
        b_we    = 1'b0;
        b_waddr = IW'(eidx_reg);
        b_re    = 1'b0;
        a_re    = 1'b0;
        a_raddr = (persp_reg ? HALF_BASE : AW'(0)) + AW'(cnt_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FEATURE:
            begin
                feat_next = compute_feature(persp_reg, ksq_reg, sq_reg, ptype_reg, pcolor_reg);
            end
            ST_BASE:
            begin
                base_next = WA'(row_sel) * ROW_STRIDE;
                cnt_next  = '0;
                b_we      = (op_reg == OP_LOAD_BIAS) && eidx_ok;
                if (op_reg == OP_READ)
                begin
                    a_re    = 1'b1;
                    a_raddr = (persp_reg ? HALF_BASE : AW'(0)) + AW'(IW'(eidx_reg));
                end
            end
            ST_WLOAD:
            begin
                w_we = fidx_ok && eidx_ok;
            end
            ST_SWEEP:
            begin
                w_re          = 1'b1;
                b_re          = 1'b1;
                a_re          = 1'b1;
                wb_valid_next = 1'b1;
                wb_idx_next   = cnt_reg;
                cnt_next      = cnt_reg + IW'(1);
            end
            ST_DRAIN:
            begin
                row_valid_next[persp_reg] = 1'b1;
            end
            ST_READ_WAIT:
            begin
                rd_res_next = eidx_ok ? a_old : 32'd0;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    read_value_next   = (op_reg == OP_READ) ? rd_res_reg : 32'd0;
                    used_feature_next = (op_reg == OP_ADD || op_reg == OP_REMOVE) ?
                                        feat_reg : 16'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // accumulator write back, one element behind the read
    assign a_we    = wb_valid_reg;
    assign a_waddr = (persp_reg ? HALF_BASE : AW'(0)) + AW'(wb_idx_reg);

    always_comb
    begin
        case (op_reg)
            OP_ADD:    a_wdata = a_old + w_ext;
            OP_REMOVE: a_wdata = a_old - w_ext;
            default:   a_wdata = b_ext;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wb_valid_reg  <= 1'b0;
            row_valid_reg <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wb_valid_reg  <= wb_valid_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            persp_reg  <= perspective;
            ksq_reg    <= king_square;
            sq_reg     <= square;
            ptype_reg  <= piece_type;
            pcolor_reg <= piece_color;
            fidx_reg   <= feature_index;
            eidx_reg   <= element_index;
            lval_reg   <= load_value;
        end
        feat_reg         <= feat_next;
        base_reg         <= base_next;
        cnt_reg          <= cnt_next;
        wb_idx_reg       <= wb_idx_next;
        rd_res_reg       <= rd_res_next;
        read_value_reg   <= read_value_next;
        used_feature_reg <= used_feature_next;
    end

    nfa_ram #(
        .WIDTH (16),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (lval_reg),
        .rd_en   (w_re),
        .rd_addr (w_raddr),
        .rd_data (w_rdata)
    );

    nfa_ram #(
        .WIDTH (16),
        .DEPTH (HALF_WIDTH)
    ) u_bias_ram (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (lval_reg),
        .rd_en   (b_re),
        .rd_addr (cnt_reg),
        .rd_data (b_rdata)
    );

    nfa_ram #(
        .WIDTH (32),
        .DEPTH (2 * HALF_WIDTH)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (a_wdata),
        .rd_en   (a_re),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    // accumulator writes only come from the element sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        a_we |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("accumulator write outside sweep");

    // a request always starts the feature stage
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_FEATURE)
        else $error("request not started");

    // a result appears only from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result without finish");

    // a half becomes valid only after a full sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(row_valid_reg[0]) || $rose(row_valid_reg[1])) |-> $past(state_reg == ST_DRAIN))
        else $error("half marked valid outside drain");

endmodule
